// ===== src/buffer_free_list_manager_defines.svh =====
// Assertion macros shared by the buffer free-list manager modules
`ifndef BUFFER_FREE_LIST_MANAGER_DEFINES_SVH
`define BUFFER_FREE_LIST_MANAGER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bfl_pkg.sv =====
// Shared types and constants of the buffer free-list manager
package bfl_pkg;

  localparam int NUM_BUFFERS = 64;
  localparam int ID_W        = $clog2(NUM_BUFFERS);
  localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);
  localparam int IN_ID_W     = 7;
  localparam int LIMIT_W     = 16;
  localparam int STATUS_W    = 3;

  localparam logic [CNT_W-1:0]   NUM_BUF_C  = CNT_W'(NUM_BUFFERS);
  localparam logic [IN_ID_W-1:0] NUM_BUF_ID = IN_ID_W'(NUM_BUFFERS);
  localparam logic [LIMIT_W:0]   OVF_BASE   = (LIMIT_W + 1)'(NUM_BUFFERS + 1);

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FIXED    = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_WAIT     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch the incoming item
    logic exec;   // carry out the latched item
  } dp_cmd_t;

endpackage

// ===== src/bfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bfl_ctrl.sv =====
// Controller: sequences accept, execute and result hand-off
`include "buffer_free_list_manager_defines.svh"

module bfl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output bfl_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  // a new item may enter once the previous result is gone or leaves now
  assign in_stall  = !((state_r == S_IDLE) || ((state_r == S_OUT) && !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= accept ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  `BFL_ASSERT_NEXT(a_accept_execs, accept, state_r == S_EXEC, "accepted item not executed")
  `BFL_ASSERT_NOW(a_hold_blocks_in, out_valid_r && out_stall, in_stall, "input taken while result held")
  `BFL_ASSERT_NOW(a_valid_in_out, out_valid_r, state_r == S_OUT, "result valid outside hand-off")

endmodule

// ===== src/bfl_dp.sv =====
// Datapath: free-id stack, counters, limit register and result registers
`include "buffer_free_list_manager_defines.svh"

module bfl_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfl_pkg::dp_cmd_t               cmd,
  input  logic                           in_cmd,
  input  logic [bfl_pkg::IN_ID_W-1:0]    in_buffer_id,
  input  logic                           cfg_we,
  input  logic [bfl_pkg::LIMIT_W-1:0]    cfg_data,
  output logic [bfl_pkg::STATUS_W-1:0]   out_status,
  output logic [bfl_pkg::ID_W-1:0]       out_granted_id,
  output logic [bfl_pkg::CNT_W-1:0]      out_free_count,
  output logic [bfl_pkg::CNT_W-1:0]      out_acquired_count,
  output logic [bfl_pkg::LIMIT_W-1:0]    out_ovf_total
);

  logic                          cmd_r;
  logic [bfl_pkg::IN_ID_W-1:0]   id_r;
  logic [bfl_pkg::CNT_W-1:0]     top_r, top_nxt;
  logic [bfl_pkg::LIMIT_W-1:0]   ovf_r, ovf_nxt;
  logic [bfl_pkg::LIMIT_W-1:0]   limit_r;
  logic [bfl_pkg::NUM_BUFFERS-1:0] vld_r;

  logic [bfl_pkg::ID_W-1:0]      pop_addr;
  logic [bfl_pkg::ID_W-1:0]      ram_q;
  logic [bfl_pkg::ID_W-1:0]      pop_id;
  logic                          push;
  logic [bfl_pkg::LIMIT_W:0]     ovf_sum;
  logic                          ovf_ok;
  bfl_pkg::status_t              status_nxt;
  logic [bfl_pkg::ID_W-1:0]      grant_nxt;

  // top of stack entry; read is issued on accept, data used in execute
  assign pop_addr = bfl_pkg::ID_W'(top_r - bfl_pkg::CNT_W'(1));
  assign pop_id   = vld_r[pop_addr] ? ram_q : pop_addr;
  assign push     = cmd.exec && (cmd_r == bfl_pkg::CMD_RELEASE) &&
                    (id_r < bfl_pkg::NUM_BUF_ID) && (top_r < bfl_pkg::NUM_BUF_C);

  assign ovf_sum = {1'b0, ovf_r} + bfl_pkg::OVF_BASE;
  assign ovf_ok  = (ovf_r != '1) &&
                   ((limit_r == '0) || (ovf_sum <= {1'b0, limit_r}));

  bfl_ram #(
    .WIDTH (bfl_pkg::ID_W),
    .DEPTH (bfl_pkg::NUM_BUFFERS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (top_r[bfl_pkg::ID_W-1:0]),
    .wdata (id_r[bfl_pkg::ID_W-1:0]),
    .raddr (pop_addr),
    .rdata (ram_q)
  );

  always_comb begin
    top_nxt    = top_r;
    ovf_nxt    = ovf_r;
    grant_nxt  = '0;
    status_nxt = bfl_pkg::ST_WAIT;
    if (cmd_r == bfl_pkg::CMD_ACQUIRE) begin
      if (top_r != '0) begin
        top_nxt    = top_r - bfl_pkg::CNT_W'(1);
        grant_nxt  = pop_id;
        status_nxt = bfl_pkg::ST_FIXED;
      end else if (ovf_ok) begin
        ovf_nxt    = ovf_r + bfl_pkg::LIMIT_W'(1);
        status_nxt = bfl_pkg::ST_OVERFLOW;
      end
    end else if (id_r < bfl_pkg::NUM_BUF_ID) begin
      if (top_r < bfl_pkg::NUM_BUF_C) begin
        top_nxt    = top_r + bfl_pkg::CNT_W'(1);
        status_nxt = bfl_pkg::ST_RELEASED;
      end else begin
        status_nxt = bfl_pkg::ST_IGNORED;
      end
    end else begin
      if (ovf_r != '0) begin
        ovf_nxt    = ovf_r - bfl_pkg::LIMIT_W'(1);
        status_nxt = bfl_pkg::ST_RELEASED;
      end else begin
        status_nxt = bfl_pkg::ST_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= bfl_pkg::NUM_BUF_C;
      ovf_r   <= '0;
      limit_r <= '0;
      vld_r   <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (cmd.exec) begin
        top_r <= top_nxt;
        ovf_r <= ovf_nxt;
      end
      if (push) begin
        vld_r[top_r[bfl_pkg::ID_W-1:0]] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_buffer_id;
    end
    if (cmd.exec) begin
      out_status         <= status_nxt;
      out_granted_id     <= grant_nxt;
      out_free_count     <= top_nxt;
      out_acquired_count <= bfl_pkg::NUM_BUF_C - top_nxt;
      out_ovf_total      <= ovf_nxt;
    end
  end

  `BFL_ASSERT_NOW(a_top_bound, 1'b1, top_r <= bfl_pkg::NUM_BUF_C, "free count above pool size")
  `BFL_ASSERT_NEXT(a_ovf_quiet, !cmd.exec, $stable(ovf_r), "overflow count moved outside execute")
  `BFL_ASSERT_NOW(a_push_room, push, top_r != bfl_pkg::NUM_BUF_C, "push onto a full stack")

endmodule

// ===== src/buffer_free_list_manager.sv =====
// An accepted item passes through S_EXEC, then its result is registered with out_valid and holds until taken.
// One item at a time: a new item can enter in the cycle its predecessor's result is taken, but
//   not before; the controller holds it off while a result is still waiting.
// Reset (synchronous, rst_n low): all fixed buffers free with entry i holding id i (per-entry
//   valid bits, no clearing pass), overflow count 0, total buffer limit 0 (unlimited).
// Configuration is always ready; total_buffer_limit is written when cfg_valid is high.
module buffer_free_list_manager (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [bfl_pkg::IN_ID_W-1:0]  in_buffer_id,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfl_pkg::STATUS_W-1:0] out_status,
  output logic [bfl_pkg::ID_W-1:0]     out_granted_id,
  output logic [bfl_pkg::CNT_W-1:0]    out_free_count,
  output logic [bfl_pkg::CNT_W-1:0]    out_acquired_count,
  output logic [bfl_pkg::LIMIT_W-1:0]  out_ovf_total,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bfl_pkg::LIMIT_W-1:0]  cfg_total_buffer_limit
);

  bfl_pkg::dp_cmd_t dp_cmd;

  // limit register is a plain flop, so writes never wait
  assign cfg_ready = 1'b1;

  // controller: one item in flight, result held in output registers
  bfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  // datapath: LIFO of free ids plus overflow accounting
  bfl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .in_cmd             (in_cmd),
    .in_buffer_id       (in_buffer_id),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_data           (cfg_total_buffer_limit),
    .out_status         (out_status),
    .out_granted_id     (out_granted_id),
    .out_free_count     (out_free_count),
    .out_acquired_count (out_acquired_count),
    .out_ovf_total      (out_ovf_total)
  );

endmodule

// ===== sim/tb_buffer_free_list_manager.sv =====
// Self-checking testbench for the buffer free-list manager
module tb_buffer_free_list_manager;

  // Run-length guard; a correct run stays well below it even with
  // the heaviest idling and back-pressure mixes.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned OVF_SAT     = (1 << bfl_pkg::LIMIT_W) - 1;
  localparam int unsigned ID_MAX      = (1 << bfl_pkg::IN_ID_W) - 1;
  localparam int unsigned PRINT_CAP   = 30;

  typedef struct packed {
    logic                          cmd;
    logic [bfl_pkg::IN_ID_W-1:0]   id;
  } request_t;

  // What the manager should answer for one request
  typedef struct {
    bfl_pkg::status_t              status;
    logic [bfl_pkg::ID_W-1:0]      granted;
    logic [bfl_pkg::CNT_W-1:0]     free_cnt;
    logic [bfl_pkg::CNT_W-1:0]     held_cnt;
    logic [bfl_pkg::LIMIT_W-1:0]   ovf_cnt;
  } pool_reply_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_cmd = bfl_pkg::CMD_ACQUIRE;
  logic [bfl_pkg::IN_ID_W-1:0]   in_buffer_id = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bfl_pkg::STATUS_W-1:0]  out_status;
  logic [bfl_pkg::ID_W-1:0]      out_granted_id;
  logic [bfl_pkg::CNT_W-1:0]     out_free_count;
  logic [bfl_pkg::CNT_W-1:0]     out_acquired_count;
  logic [bfl_pkg::LIMIT_W-1:0]   out_ovf_total;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bfl_pkg::LIMIT_W-1:0]   cfg_total_buffer_limit = '0;

  buffer_free_list_manager dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cmd                 (in_cmd),
    .in_buffer_id           (in_buffer_id),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_granted_id         (out_granted_id),
    .out_free_count         (out_free_count),
    .out_acquired_count     (out_acquired_count),
    .out_ovf_total          (out_ovf_total),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_total_buffer_limit (cfg_total_buffer_limit)
  );

  // Shadow copy of the pool: LIFO of free ids, its depth, the overflow tally
  // and the programmed buffer limit.
  logic [bfl_pkg::ID_W-1:0]  pool_stack [bfl_pkg::NUM_BUFFERS];
  int unsigned      pool_top = bfl_pkg::NUM_BUFFERS;
  int unsigned      pool_ovf = 0;
  int unsigned      pool_limit = 0;

  request_t         request_queue[$];   // items waiting to be driven
  pool_reply_t      awaited_replies[$]; // answers owed by the manager

  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      error_count = 0;
  int unsigned      requests_sent = 0;
  int unsigned      replies_checked = 0;
  int unsigned      limits_written = 0;
  int unsigned      cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Works out the manager's answer to one request and moves the shadow pool on.
  function automatic pool_reply_t serve_request(logic cmd,
                                                logic [bfl_pkg::IN_ID_W-1:0] id);
    pool_reply_t r;
    r.granted = '0;
    if (cmd == bfl_pkg::CMD_ACQUIRE) begin
      if (pool_top > 0) begin
        pool_top--;
        r.granted = pool_stack[pool_top];
        r.status  = bfl_pkg::ST_FIXED;
      end else if (pool_ovf < OVF_SAT &&
                   (pool_limit == 0 ||
                    bfl_pkg::NUM_BUFFERS + pool_ovf + 1 <= pool_limit)) begin
        pool_ovf++;
        r.status = bfl_pkg::ST_OVERFLOW;
      end else begin
        r.status = bfl_pkg::ST_WAIT;
      end
    end else if (id < bfl_pkg::NUM_BUFFERS) begin
      // no duplicate check: a free id goes back on as long as there is room
      if (pool_top < bfl_pkg::NUM_BUFFERS) begin
        pool_stack[pool_top] = id[bfl_pkg::ID_W-1:0];
        pool_top++;
        r.status = bfl_pkg::ST_RELEASED;
      end else begin
        r.status = bfl_pkg::ST_IGNORED;
      end
    end else begin
      if (pool_ovf > 0) begin
        pool_ovf--;
        r.status = bfl_pkg::ST_RELEASED;
      end else begin
        r.status = bfl_pkg::ST_IGNORED;
      end
    end
    r.free_cnt = pool_top[bfl_pkg::CNT_W-1:0];
    r.held_cnt = bfl_pkg::CNT_W'(bfl_pkg::NUM_BUFFERS - pool_top);
    r.ovf_cnt  = pool_ovf[bfl_pkg::LIMIT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < PRINT_CAP)
      $display("MISMATCH %s at reply %0d: got %0d, wanted %0d",
               what, replies_checked, got, want);
    error_count++;
  endtask

  // Driver: presents the next queued item, holds it while stalled, and
  // records the expected answer at the edge it is taken.
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(serve_request(in_cmd, in_buffer_id));
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= nxt.cmd;
          in_buffer_id <= nxt.id;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each reply taken against the oldest awaited one and
  // throws random back-pressure at the result side.
  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("reply with nothing awaited, status",
                          longint'(out_status), longint'(-1));
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", longint'(out_status), longint'(want.status));
          if (out_granted_id !== want.granted)
            report_mismatch("granted_id", longint'(out_granted_id),
                            longint'(want.granted));
          if (out_free_count !== want.free_cnt)
            report_mismatch("free_count", longint'(out_free_count),
                            longint'(want.free_cnt));
          if (out_acquired_count !== want.held_cnt)
            report_mismatch("acquired_count", longint'(out_acquired_count),
                            longint'(want.held_cnt));
          if (out_ovf_total !== want.ovf_cnt)
            report_mismatch("overflow total", longint'(out_ovf_total),
                            longint'(want.ovf_cnt));
        end
        replies_checked++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Programme the buffer limit; only called with the manager idle.
  task automatic write_limit(logic [bfl_pkg::LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid              <= 1'b1;
    cfg_total_buffer_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    pool_limit = 32'(value);
    limits_written++;
  endtask

  task automatic queue_request(logic cmd, int unsigned id);
    request_t req;
    req.cmd = cmd;
    req.id  = id[bfl_pkg::IN_ID_W-1:0];
    request_queue.push_back(req);
  endtask

  // Random traffic in runs that lean towards grabbing or returning buffers,
  // so the free stack regularly drains empty and fills right up again.
  task automatic queue_traffic(int unsigned count);
    int unsigned made = 0;
    int unsigned run_len;
    bit          grabbing;
    logic        cmd;
    while (made < count) begin
      run_len  = $urandom_range(1, 80);
      grabbing = 1'($urandom_range(1));
      for (int unsigned k = 0; k < run_len && made < count; k++) begin
        if ($urandom_range(99) < 8)
          cmd = 1'($urandom_range(1));     // noise
        else if (grabbing)
          cmd = ($urandom_range(99) < 85) ? bfl_pkg::CMD_ACQUIRE : bfl_pkg::CMD_RELEASE;
        else
          cmd = ($urandom_range(99) < 85) ? bfl_pkg::CMD_RELEASE : bfl_pkg::CMD_ACQUIRE;
        if (cmd == bfl_pkg::CMD_ACQUIRE)
          queue_request(cmd, $urandom_range(ID_MAX));   // id is don't-care here
        else if ($urandom_range(99) < 80)
          queue_request(cmd, $urandom_range(bfl_pkg::NUM_BUFFERS - 1));
        else
          queue_request(cmd, $urandom_range(bfl_pkg::NUM_BUFFERS, ID_MAX));
        made++;
      end
    end
  endtask

  // Block until everything queued has gone in and every reply has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0);
  endtask

  task automatic random_phase(logic [bfl_pkg::LIMIT_W-1:0] limit, int unsigned send_pct,
                              int unsigned recv_pct, int unsigned count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    write_limit(limit);
    queue_traffic(count);
    wait_drained();
  endtask

  // Cycle guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d replies outstanding",
             cycle_count, awaited_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence
  initial begin
    for (int i = 0; i < bfl_pkg::NUM_BUFFERS; i++)
      pool_stack[i] = i[bfl_pkg::ID_W-1:0];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: releases onto a full stack and an empty overflow tally,
    // a double release of an id that is already free, a refill to full, then one more acquire.
    write_limit(16'd66);
    queue_request(bfl_pkg::CMD_RELEASE, 0);
    queue_request(bfl_pkg::CMD_RELEASE, bfl_pkg::NUM_BUFFERS - 1);
    queue_request(bfl_pkg::CMD_RELEASE, bfl_pkg::NUM_BUFFERS);
    queue_request(bfl_pkg::CMD_RELEASE, ID_MAX);
    queue_request(bfl_pkg::CMD_ACQUIRE, ID_MAX);
    queue_request(bfl_pkg::CMD_ACQUIRE, 85);
    queue_request(bfl_pkg::CMD_RELEASE, 5);
    queue_request(bfl_pkg::CMD_ACQUIRE, 42);
    queue_request(bfl_pkg::CMD_RELEASE, 42);
    queue_request(bfl_pkg::CMD_RELEASE, 21);
    queue_request(bfl_pkg::CMD_RELEASE, 42);
    queue_request(bfl_pkg::CMD_ACQUIRE, 0);
    queue_request(bfl_pkg::CMD_RELEASE, 85);
    queue_request(bfl_pkg::CMD_RELEASE, 64);
    wait_drained();

    // Random phases across limits and idling patterns; 64 forbids any
    // overflow, 65535 is the widest finite limit, 0 leaves it unbounded.
    random_phase(16'd0,     0,  0,  290);
    random_phase(16'd64,    79, 0,  290);
    random_phase(16'hffff,  0,  79, 290);
    random_phase(16'd70,    17, 17, 290);
    random_phase(bfl_pkg::LIMIT_W'($urandom_range(65, 200)), 17, 17, 290);

    // Unbounded overflow: empty the stack, take a few overflow buffers,
    // return more of them than were granted, then reuse a fixed id.
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    write_limit(16'd0);
    for (int unsigned n = 0; n < bfl_pkg::NUM_BUFFERS + 6; n++)
      queue_request(bfl_pkg::CMD_ACQUIRE, $urandom_range(ID_MAX));
    for (int unsigned n = 0; n < 8; n++)
      queue_request(bfl_pkg::CMD_RELEASE, $urandom_range(bfl_pkg::NUM_BUFFERS, ID_MAX));
    queue_request(bfl_pkg::CMD_RELEASE, 17);
    queue_request(bfl_pkg::CMD_ACQUIRE, 3);
    queue_request(bfl_pkg::CMD_ACQUIRE, 9);
    wait_drained();

    // Let any stray reply surface before the verdict
    repeat (6) @(posedge clk);
    if (awaited_replies.size() != 0)
      report_mismatch("replies never delivered", longint'(0),
                      longint'(awaited_replies.size()));

    $display("Ran %0d requests, %0d replies checked, %0d limit writes, in %0d cycles",
             requests_sent, replies_checked, limits_written, cycle_count);
    $display("Idle and stall mixes varied per phase; stack drained and refilled, overflow taken and returned");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
